// ----- sv/tdpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared types and constants for the trial division prime classifier.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int VALUE_WIDTH = 16;
  // Bit counter for the restoring remainder loop.
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  // Running square of the divisor; it can pass the value by a little.
  localparam int SQ_W        = VALUE_WIDTH + 2;

  typedef enum logic [1:0] {
    CLASS_NEITHER   = 2'd0,
    CLASS_PRIME     = 2'd1,
    CLASS_COMPOSITE = 2'd2
  } class_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic   load;      // take a new value, divisor back to two
    logic   init_div;  // start one remainder computation
    logic   div_step;  // one restoring step
    logic   next_div;  // advance to the next candidate
    logic   capture;   // write the result register
    class_t verdict;
  } tdpc_cmd_t;

  typedef struct packed {
    logic lt2;       // value is 0 or 1
    logic sq_gt_n;   // divisor squared exceeds the value
    logic div_last;  // last remainder step in progress
    logic rem_zero;  // remainder is zero
  } tdpc_status_t;

endpackage

// ----- sv/tdpc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_datapath
// Held value, candidate divisor with its running square, a one bit per
// cycle restoring remainder unit, and the result register.
// ----------------------------------------------------------------------------
module tdpc_datapath (
  input  logic                                clk,
  input  logic [tdpc_pkg::VALUE_WIDTH-1:0]    value,
  input  tdpc_pkg::tdpc_cmd_t                 cmd,
  output tdpc_pkg::tdpc_status_t              status,
  output logic [1:0]                          number_class,
  output logic [tdpc_pkg::VALUE_WIDTH-1:0]    echoed_value
);

  localparam int W = tdpc_pkg::VALUE_WIDTH;

  logic [W-1:0]                  held_value;
  logic [W-1:0]                  trial_divisor;
  logic [tdpc_pkg::SQ_W-1:0]     trial_square;
  logic [W-1:0]                  rem;
  logic [W-1:0]                  dividend;
  logic [tdpc_pkg::CNT_W-1:0]    bit_cnt;
  tdpc_pkg::class_t              class_q;

  logic [W:0]                    rem_shift;
  logic [W:0]                    rem_sub;
  logic                          rem_ge;

  assign rem_shift = {rem, dividend[W-1]};
  assign rem_sub   = rem_shift - {1'b0, trial_divisor};
  assign rem_ge    = rem_shift >= {1'b0, trial_divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_value    <= value;
      trial_divisor <= W'(2);
      trial_square  <= tdpc_pkg::SQ_W'(4);
    end else if (cmd.next_div) begin
      trial_divisor <= trial_divisor + W'(1);
      // (d+1)^2 = d^2 + 2d + 1
      trial_square  <= trial_square + {1'b0, trial_divisor, 1'b1};
    end
    if (cmd.init_div) begin
      rem      <= '0;
      dividend <= held_value;
      bit_cnt  <= tdpc_pkg::CNT_W'(W - 1);
    end else if (cmd.div_step) begin
      rem      <= rem_ge ? rem_sub[W-1:0] : rem_shift[W-1:0];
      dividend <= {dividend[W-2:0], 1'b0};
      bit_cnt  <= bit_cnt - tdpc_pkg::CNT_W'(1);
    end
    if (cmd.capture) begin
      class_q      <= cmd.verdict;
      echoed_value <= held_value;
    end
  end

  assign number_class    = class_q;
  assign status.lt2      = (held_value[W-1:1] == '0);
  assign status.sq_gt_n  = trial_square > {2'b00, held_value};
  assign status.div_last = (bit_cnt == '0);
  assign status.rem_zero = (rem == '0);

endmodule

// ----- sv/tdpc_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_controller
// Sequencer for the trial loop, verdict register and output valid flag.
// ----------------------------------------------------------------------------
module tdpc_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  tdpc_pkg::tdpc_status_t status,
  output tdpc_pkg::tdpc_cmd_t    cmd
);

  tdpc_pkg::state_t state, state_next;
  tdpc_pkg::class_t verdict, verdict_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpc_pkg::S_IDLE;
      verdict   <= tdpc_pkg::CLASS_NEITHER;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    unique case (state)
      tdpc_pkg::S_IDLE: begin
        if (in_valid) state_next = tdpc_pkg::S_CHECK;
      end
      tdpc_pkg::S_CHECK: begin
        priority if (status.lt2) begin
          verdict_next = tdpc_pkg::CLASS_NEITHER;
          state_next   = tdpc_pkg::S_DONE;
        end else if (status.sq_gt_n) begin
          verdict_next = tdpc_pkg::CLASS_PRIME;
          state_next   = tdpc_pkg::S_DONE;
        end else begin
          state_next   = tdpc_pkg::S_DIV;
        end
      end
      tdpc_pkg::S_DIV: begin
        if (status.div_last) state_next = tdpc_pkg::S_TEST;
      end
      tdpc_pkg::S_TEST: begin
        if (status.rem_zero) begin
          verdict_next = tdpc_pkg::CLASS_COMPOSITE;
          state_next   = tdpc_pkg::S_DONE;
        end else begin
          state_next   = tdpc_pkg::S_CHECK;
        end
      end
      tdpc_pkg::S_DONE: begin
        if (out_free) state_next = tdpc_pkg::S_IDLE;
      end
      default: state_next = tdpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.verdict = verdict;
    in_stall    = 1'b1;
    unique case (state)
      tdpc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tdpc_pkg::S_CHECK: begin
        cmd.init_div = !status.lt2 && !status.sq_gt_n;
      end
      tdpc_pkg::S_DIV:  cmd.div_step = 1'b1;
      tdpc_pkg::S_TEST: cmd.next_div = !status.rem_zero;
      tdpc_pkg::S_DONE: cmd.capture  = out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/trial_division_prime_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_classifier
// Classifies an unsigned integer as neither, prime or composite.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, value): one transfer per integer.
//   Output channel (out_valid / out_stall, number_class, echoed_value): one
//   transfer per input, in input order. number_class is 0 for 0 and 1,
//   1 for a prime, 2 for a composite; echoed_value is the classified value.
//   Operation: candidates d = 2, 3, ... are tried while d*d <= value; the
//   square is kept incrementally, so no multiplier is needed. Each trial
//   computes value mod d in a restoring remainder unit, one bit per cycle.
//   Sequence: each trial passes through the check state, the remainder
//   steps and the test state. A 16-bit prime near 65535 takes 254 trials;
//   0 to 3 are decided in the check state with no trial.
//   Throughput: one item at a time; in_stall is low only when idle, which
//   is the cycle after the result is registered.
//   A finished result sits in the output register; while the receiver stalls,
//   it is held, and the next item is taken but its result waits in the done state.
//   Reset (rst, synchronous): returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module trial_division_prime_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tdpc_pkg::VALUE_WIDTH-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       number_class,
  output logic [tdpc_pkg::VALUE_WIDTH-1:0] echoed_value
);

  tdpc_pkg::tdpc_cmd_t    cmd;
  tdpc_pkg::tdpc_status_t status;

  // Sequencer: walks CHECK -> DIV -> TEST per candidate.
  tdpc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Value, divisor, square, remainder unit and result register.
  tdpc_datapath u_dp (
    .clk          (clk),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .number_class (number_class),
    .echoed_value (echoed_value)
  );

endmodule

// ----- sv/tdpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_checker
// Port-level checks for the prime classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tdpc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       number_class,
  input logic [tdpc_pkg::VALUE_WIDTH-1:0] echoed_value
);

  // Busy right after taking an item.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // Held result does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(number_class)
      && $stable(echoed_value))
    else $error("stalled result changed");

  a_neither: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_class == tdpc_pkg::CLASS_NEITHER |-> echoed_value < 2)
    else $error("neither class on value above one");

  a_prime_composite: assert property (@(posedge clk) disable iff (rst)
    out_valid && (number_class == tdpc_pkg::CLASS_PRIME ||
      number_class == tdpc_pkg::CLASS_COMPOSITE) |-> echoed_value >= 2)
    else $error("prime or composite on value below two");

  a_composite_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_class == tdpc_pkg::CLASS_COMPOSITE |-> echoed_value >= 4)
    else $error("composite below four");

endmodule

bind trial_division_prime_classifier tdpc_checker u_tdpc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .number_class (number_class),
  .echoed_value (echoed_value)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the trial division prime classifier.
// Sends directed and random integers over the input channel, works out the
// expected class of each one, and checks every result transfer against
// the oldest outstanding prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  // No transfer on either channel for this many cycles means a hang.
  // The slowest item is a large prime, plus any stalls.
  localparam int QUIET_LIMIT  = 50000;
  // Drain time after the last result: long enough for a stray result.
  localparam int DRAIN_CYCLES = 5000;
  localparam int RANDOM_ITEMS = 80;

  // Kinds of random value; two of them target the deep end of the search.
  typedef enum int {
    PICK_SMALL,    // 0..255, quick decisions
    PICK_ANY,      // full range
    PICK_PRODUCT,  // product of two values in 2..255
    PICK_PRIME     // prime, longest search
  } value_kind_t;

  typedef struct {
    tdpc_pkg::class_t                 number_class;
    logic [tdpc_pkg::VALUE_WIDTH-1:0] value;
  } verdict_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             out_stall = 1'b0;
  logic [tdpc_pkg::VALUE_WIDTH-1:0] value     = '0;
  logic                             in_stall;
  logic                             out_valid;
  logic [1:0]                       number_class;
  logic [tdpc_pkg::VALUE_WIDTH-1:0] echoed_value;

  // Values waiting to be driven, and classes waiting to come back.
  logic [tdpc_pkg::VALUE_WIDTH-1:0] values_to_send[$];
  verdict_t                         expected_verdicts[$];

  // Predictor state: last value, divisor that decided it, divisors seen.
  logic [tdpc_pkg::VALUE_WIDTH-1:0] last_value       = '0;
  logic [tdpc_pkg::VALUE_WIDTH-1:0] deciding_divisor = '0;
  logic [1:0]                       divisors_seen    = '0;

  // Transfer flags from the last rising edge, read by the drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  int values_queued = 0;
  int values_taken  = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  // Idle / stall bookkeeping; a burst flag gives stretches with no idling.
  int gap_left   = 0;
  int hold_left  = 0;
  bit in_burst   = 1'b0;
  bit out_burst  = 1'b0;

  trial_division_prime_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .number_class (number_class),
    .echoed_value (echoed_value)
  );

  always #4 clk = ~clk;

  // Trial division up to the square root. The first divisor found is the
  // smallest proper one; no divisor found means prime. 0 and 1 are neither.
  function automatic tdpc_pkg::class_t classify_value(
    input  logic [tdpc_pkg::VALUE_WIDTH-1:0] n,
    output logic [tdpc_pkg::VALUE_WIDTH-1:0] factor
  );
    longint unsigned d;
    factor = n;
    if (n < 2) return tdpc_pkg::CLASS_NEITHER;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        factor = d[tdpc_pkg::VALUE_WIDTH-1:0];
        return tdpc_pkg::CLASS_COMPOSITE;
      end
    end
    return tdpc_pkg::CLASS_PRIME;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: changes at the falling edge. A pending transfer holds
  // until taken; after each transfer a fresh random gap is drawn.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) begin
        gap_left = in_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (values_to_send.size() != 0) begin
        value    <= values_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall driver: after each result transfer, draw how many cycles
  // of valid the next result is held off. Stall stays up until that count
  // runs out, so it also covers the compute phase and the result wait.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_taken) begin
      hold_left = out_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
    end
    out_stall <= (hold_left != 0);
    if (hold_left != 0 && out_valid) hold_left--;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge. Results are checked before the
  // new input is predicted, so a same-edge input never pairs with them.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    verdict_t                         want;
    tdpc_pkg::class_t                 verdict;
    logic [tdpc_pkg::VALUE_WIDTH-1:0] factor;

    in_taken  <= !rst && in_valid && !in_stall;
    out_taken <= !rst && out_valid && !out_stall;

    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: number_class %0d, echoed_value %0d",
               number_class, echoed_value);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (number_class !== want.number_class) begin
          $error("number_class: expected %0d, got %0d", want.number_class, number_class);
          fail_count++;
        end
        if (echoed_value !== want.value) begin
          $error("echoed_value: expected %0d, got %0d", want.value, echoed_value);
          fail_count++;
        end
      end
    end

    if (!rst && in_valid && !in_stall) begin
      verdict = classify_value(value, factor);
      expected_verdicts.push_back('{verdict, value});
      last_value       <= value;
      deciding_divisor <= factor;
      case (verdict)
        tdpc_pkg::CLASS_PRIME:     divisors_seen <= 2'd2;
        tdpc_pkg::CLASS_COMPOSITE: divisors_seen <= 2'd3;
        default:                   divisors_seen <= value[1:0];  // 0 or 1
      endcase
      values_taken++;
    end
  end

  // Hang detection: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("trial_division_prime_classifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [tdpc_pkg::VALUE_WIDTH-1:0] directed[21];
    logic [tdpc_pkg::VALUE_WIDTH-1:0] n;
    logic [tdpc_pkg::VALUE_WIDTH-1:0] factor;
    int unsigned                      a;
    int unsigned                      b;
    int unsigned                      pick;
    value_kind_t                      kind;

    directed = '{
      16'd0, 16'd1,                         // neither class
      16'd2, 16'd3, 16'd5,                  // smallest primes
      16'd4, 16'd9, 16'd25, 16'd49,         // prime squares: bound hit exactly
      16'd63001, 16'd65025,                 // 251^2, 255^2
      16'd64507,                            // 251 * 257, search runs long
      16'd32768, 16'h5555, 16'hAAAA,        // power of two, bit patterns
      16'd4093, 16'd32749,                  // mid-size primes
      16'd65519, 16'd65521,                 // largest primes, longest search
      16'd65534, 16'd65535                  // all ones and near it
    };

    hold_left = $urandom_range(0, 15);
    gap_left  = $urandom_range(0, 15);

    foreach (directed[i]) values_to_send.push_back(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = value_kind_t'($urandom_range(0, 3));
      case (kind)
        PICK_SMALL: begin
          pick = $urandom_range(0, 255);
          n    = pick[tdpc_pkg::VALUE_WIDTH-1:0];
        end
        PICK_ANY: begin
          pick = $urandom_range(0, 65535);
          n    = pick[tdpc_pkg::VALUE_WIDTH-1:0];
        end
        PICK_PRODUCT: begin
          a    = $urandom_range(2, 255);
          b    = $urandom_range(2, 255);
          pick = a * b;
          n    = pick[tdpc_pkg::VALUE_WIDTH-1:0];
        end
        default: begin
          // step down from a random start to the nearest prime
          pick = $urandom_range(2, 65535);
          n    = pick[tdpc_pkg::VALUE_WIDTH-1:0];
          while (classify_value(n, factor) != tdpc_pkg::CLASS_PRIME) n--;
        end
      endcase
      values_to_send.push_back(n);
    end
    values_queued = values_to_send.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (values_taken != values_queued) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("trial_division_prime_classifier: match");
    end else begin
      $display("trial_division_prime_classifier: mismatch");
    end
    $finish;
  end

endmodule
